// File: rtl/iodba_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and register codes for the IMU offset/deadband/average block.
package iodba_pkg;

    localparam int AXES        = 6;
    localparam int ACC_AXES    = 3;
    localparam int WINDOW      = 7;
    localparam int CAL_SAMPLES = 10;
    localparam int ONE_G       = 256;

    localparam int ACC_W      = 10;
    localparam int RATE_W     = 16;
    localparam int OUT_W      = 29;
    localparam int GAIN_W     = 20;
    localparam int THR_W      = 28;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 28;
    localparam int FRAC_W     = 8;

    localparam int IN_TDATA_W  = ((ACC_AXES * ACC_W + (AXES - ACC_AXES) * RATE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((AXES * OUT_W + 7) / 8) * 8;

    // Calibration accumulator and its constant divider (exact reciprocal multiply).
    localparam int CNT_W       = $clog2(CAL_SAMPLES + 1);
    localparam int CAL_SUM_W   = RATE_W + $clog2(CAL_SAMPLES);
    localparam int CAL_SHIFT   = CAL_SUM_W + $clog2(CAL_SAMPLES);
    localparam int CAL_RECIP_W = CAL_SUM_W + 2;
    localparam logic [63:0] CAL_RECIP =
        ((64'd1 << CAL_SHIFT) + 64'(CAL_SAMPLES - 1)) / 64'(CAL_SAMPLES);

    localparam int OFS_W    = RATE_W + 1;
    localparam int DIFF_W   = RATE_W + 2;
    localparam int PROD_W   = DIFF_W + GAIN_W + 1;
    localparam int SCALED_W = PROD_W - FRAC_W;

    // Window sum and its constant divider.
    localparam int WSUM_W      = OUT_W + $clog2(WINDOW);
    localparam int WIN_SHIFT   = WSUM_W + $clog2(WINDOW);
    localparam int WIN_RECIP_W = WSUM_W + 2;
    localparam logic [63:0] WIN_RECIP =
        ((64'd1 << WIN_SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW);

    // Raw axis order: accel x, y, z, gyro x, y, z.
    localparam int AXIS_ACC_Z  = 2;
    localparam int AXIS_RATE_X = 3;
    localparam int AXIS_RATE_Y = 4;
    localparam int AXIS_RATE_Z = 5;

    // Output lane to raw axis; the gyro x and y axes trade places.
    localparam int SRC_AXIS [AXES] = '{0, 1, AXIS_ACC_Z, AXIS_RATE_Y, AXIS_RATE_X, AXIS_RATE_Z};

    localparam logic [CFG_ADDR_W-1:0] REG_ACC_GAIN  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_GAIN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ACC_THR   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_THR  = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_RST = 20'd65536;
    localparam logic [THR_W-1:0]  THR_RST  = '0;

    typedef logic signed [RATE_W-1:0]    t_raw;
    typedef logic signed [OFS_W-1:0]     t_ofs;
    typedef logic signed [CAL_SUM_W-1:0] t_csum;
    typedef logic signed [OUT_W-1:0]     t_val;
    typedef logic signed [WSUM_W-1:0]    t_wsum;

    typedef struct packed {
        logic done;
        logic busy;
    } t_cal_status;

endpackage

// File: rtl/iodba_cal.sv
`timescale 1ns / 1ps
// Calibration accumulator: sums the first samples and forms the per-axis offsets.
module iodba_cal (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  iodba_pkg::t_raw         i_raw [iodba_pkg::AXES],
    output iodba_pkg::t_cal_status  o_status,
    output iodba_pkg::t_ofs         o_ofs [iodba_pkg::AXES]
);

    localparam int SUM_W  = iodba_pkg::CAL_SUM_W;
    localparam int RCP_W  = iodba_pkg::CAL_RECIP_W;
    localparam int CNT_W  = iodba_pkg::CNT_W;
    localparam int OFS_W  = iodba_pkg::OFS_W;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(iodba_pkg::CAL_RECIP);

    logic [CNT_W-1:0]    r_count;
    logic                r_busy;
    iodba_pkg::t_csum    r_sum [iodba_pkg::AXES];
    iodba_pkg::t_csum    n_sum [iodba_pkg::AXES];
    iodba_pkg::t_ofs     r_ofs [iodba_pkg::AXES];
    iodba_pkg::t_ofs     n_ofs [iodba_pkg::AXES];
    logic [SUM_W-1:0]       mag  [iodba_pkg::AXES];
    logic [SUM_W+RCP_W-1:0] prod [iodba_pkg::AXES];
    logic [OFS_W-1:0]       quo  [iodba_pkg::AXES];

    always_comb begin
        for (int a = 0; a < iodba_pkg::AXES; a++) begin
            n_sum[a] = r_sum[a] + SUM_W'(i_raw[a]);
            // Divide toward zero: work on the magnitude, then restore the sign.
            mag[a]   = r_sum[a][SUM_W-1] ? SUM_W'(-r_sum[a]) : SUM_W'(r_sum[a]);
            prod[a]  = mag[a] * RECIP;
            quo[a]   = OFS_W'(prod[a] >> iodba_pkg::CAL_SHIFT);
            n_ofs[a] = r_sum[a][SUM_W-1] ? -signed'(quo[a]) : signed'(quo[a]);
            if (a == iodba_pkg::AXIS_ACC_Z) begin
                n_ofs[a] = n_ofs[a] - OFS_W'(iodba_pkg::ONE_G);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            for (int a = 0; a < iodba_pkg::AXES; a++) begin
                r_sum[a] <= '0;
            end
        end else begin
            r_busy <= i_take && (r_count == CNT_W'(iodba_pkg::CAL_SAMPLES - 1));
            if (i_take) begin
                r_count <= r_count + 1'b1;
                r_sum   <= n_sum;
            end
        end
    end

    // The offsets are formed in the cycle after the last calibration sample.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_ofs <= n_ofs;
        end
    end

    assign o_status.done = (r_count == CNT_W'(iodba_pkg::CAL_SAMPLES));
    assign o_status.busy = r_busy;
    assign o_ofs         = r_ofs;

endmodule

// File: rtl/iodba_scale.sv
`timescale 1ns / 1ps
// Offset removal, axis swap, gain multiply (registered) and Q8 deadband per lane.
module iodba_scale (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  iodba_pkg::t_raw                 i_raw [iodba_pkg::AXES],
    input  iodba_pkg::t_ofs                 i_ofs [iodba_pkg::AXES],
    input  logic [iodba_pkg::GAIN_W-1:0]    i_acc_gain,
    input  logic [iodba_pkg::GAIN_W-1:0]    i_rate_gain,
    input  logic [iodba_pkg::THR_W-1:0]     i_acc_thr,
    input  logic [iodba_pkg::THR_W-1:0]     i_rate_thr,
    output iodba_pkg::t_val                 o_val [iodba_pkg::AXES]
);

    localparam int DIFF_W = iodba_pkg::DIFF_W;
    localparam int PROD_W = iodba_pkg::PROD_W;
    localparam int SC_W   = iodba_pkg::SCALED_W;
    localparam int OUT_W  = iodba_pkg::OUT_W;
    localparam int FRAC_W = iodba_pkg::FRAC_W;
    localparam logic signed [SC_W-1:0] SC_MAX = {{(SC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [SC_W-1:0] SC_MIN = {{(SC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    logic signed [DIFF_W-1:0]     diff   [iodba_pkg::AXES];
    logic signed [iodba_pkg::GAIN_W:0] gain [iodba_pkg::AXES];
    logic signed [PROD_W-1:0]     r_prod [iodba_pkg::AXES];
    logic signed [PROD_W-1:0]     n_prod [iodba_pkg::AXES];
    logic [FRAC_W-1:0]            bias   [iodba_pkg::AXES];
    logic signed [PROD_W-1:0]     adj    [iodba_pkg::AXES];
    logic signed [SC_W-1:0]       scaled [iodba_pkg::AXES];
    iodba_pkg::t_val              clip   [iodba_pkg::AXES];
    logic [OUT_W-1:0]             mag    [iodba_pkg::AXES];
    logic [iodba_pkg::THR_W-1:0]  thr    [iodba_pkg::AXES];

    always_comb begin
        for (int a = 0; a < iodba_pkg::AXES; a++) begin
            diff[a] = DIFF_W'(i_raw[iodba_pkg::SRC_AXIS[a]])
                    - DIFF_W'(i_ofs[iodba_pkg::SRC_AXIS[a]]);
            gain[a] = (a < iodba_pkg::ACC_AXES) ? signed'({1'b0, i_acc_gain})
                                                 : signed'({1'b0, i_rate_gain});
            n_prod[a] = diff[a] * gain[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    always_comb begin
        for (int a = 0; a < iodba_pkg::AXES; a++) begin
            // Q16 times counts down to Q8, rounded toward zero.
            bias[a]   = r_prod[a][PROD_W-1] ? {FRAC_W{1'b1}} : '0;
            adj[a]    = r_prod[a] + signed'(PROD_W'(bias[a]));
            scaled[a] = adj[a][PROD_W-1:FRAC_W];
            if (scaled[a] > SC_MAX) begin
                clip[a] = OUT_W'(SC_MAX);
            end else if (scaled[a] < SC_MIN) begin
                clip[a] = OUT_W'(SC_MIN);
            end else begin
                clip[a] = OUT_W'(scaled[a]);
            end
            mag[a] = clip[a][OUT_W-1] ? OUT_W'(-clip[a]) : OUT_W'(clip[a]);
            thr[a] = (a < iodba_pkg::ACC_AXES) ? i_acc_thr : i_rate_thr;
            o_val[a] = (mag[a] < OUT_W'(thr[a])) ? '0 : clip[a];
        end
    end

endmodule

// File: rtl/iodba_window.sv
`timescale 1ns / 1ps
// Per-axis history shift line with a running window sum.
module iodba_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  iodba_pkg::t_val   i_val [iodba_pkg::AXES],
    output iodba_pkg::t_wsum  o_sum [iodba_pkg::AXES]
);

    localparam int WSUM_W = iodba_pkg::WSUM_W;

    iodba_pkg::t_val   r_hist [iodba_pkg::WINDOW][iodba_pkg::AXES];
    iodba_pkg::t_wsum  r_sum  [iodba_pkg::AXES];
    iodba_pkg::t_wsum  n_sum  [iodba_pkg::AXES];

    // The new sample enters and the oldest one drops out of the sum.
    always_comb begin
        for (int a = 0; a < iodba_pkg::AXES; a++) begin
            n_sum[a] = r_sum[a] + WSUM_W'(i_val[a])
                     - WSUM_W'(r_hist[iodba_pkg::WINDOW-1][a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < iodba_pkg::AXES; a++) begin
                r_sum[a] <= '0;
                for (int k = 0; k < iodba_pkg::WINDOW; k++) begin
                    r_hist[k][a] <= '0;
                end
            end
        end else if (i_shift) begin
            r_sum <= n_sum;
            for (int a = 0; a < iodba_pkg::AXES; a++) begin
                r_hist[0][a] <= i_val[a];
                for (int k = 1; k < iodba_pkg::WINDOW; k++) begin
                    r_hist[k][a] <= r_hist[k-1][a];
                end
            end
        end
    end

    assign o_sum = r_sum;

endmodule

// File: rtl/iodba_mean.sv
`timescale 1ns / 1ps
// Window mean: divides each window sum by the window length toward zero, registered.
module iodba_mean (
    input  logic              i_clk,
    input  logic              i_load,
    input  iodba_pkg::t_wsum  i_sum  [iodba_pkg::AXES],
    output iodba_pkg::t_val   o_mean [iodba_pkg::AXES]
);

    localparam int WSUM_W = iodba_pkg::WSUM_W;
    localparam int RCP_W  = iodba_pkg::WIN_RECIP_W;
    localparam int OUT_W  = iodba_pkg::OUT_W;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(iodba_pkg::WIN_RECIP);

    logic [WSUM_W-1:0]       mag  [iodba_pkg::AXES];
    logic [WSUM_W+RCP_W-1:0] prod [iodba_pkg::AXES];
    logic [OUT_W-1:0]        quo  [iodba_pkg::AXES];
    iodba_pkg::t_val         r_mean [iodba_pkg::AXES];
    iodba_pkg::t_val         n_mean [iodba_pkg::AXES];

    // The mean of in-range samples is itself in range, so no clamp is needed.
    always_comb begin
        for (int a = 0; a < iodba_pkg::AXES; a++) begin
            mag[a]    = i_sum[a][WSUM_W-1] ? WSUM_W'(-i_sum[a]) : WSUM_W'(i_sum[a]);
            prod[a]   = mag[a] * RECIP;
            quo[a]    = OUT_W'(prod[a] >> iodba_pkg::WIN_SHIFT);
            n_mean[a] = i_sum[a][WSUM_W-1] ? -signed'(quo[a]) : signed'(quo[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mean <= n_mean;
        end
    end

    assign o_mean = r_mean;

endmodule

// File: rtl/imu_offset_deadband_average.sv
`timescale 1ns / 1ps
// Top level of the IMU offset calibration, deadband and moving-average block.
//
// Input stream: one six-axis raw sample per transaction (three 10-bit accel
// counts, three 16-bit gyro counts). Output stream: six 29-bit signed Q8
// window means. The first CAL_SAMPLES input transactions are calibration
// samples and produce no output; after the last of them the input side is
// held off while the offsets are formed.
// Afterwards every input transaction produces exactly one output transaction.
// The path is four register stages (input, gain product, window sum, mean),
// and one sample per cycle is sustained while the receiver does not stall.
// Gains and deadband thresholds come from a write port and must only be
// changed while no sample is in flight.
// Reset clears the calibration count, the sums, the history and all stage
// valids, and restores the register defaults. When the receiver stalls,
// the stages ahead of it keep filling, so up to four samples are held
// before the input side is stalled in turn.
module imu_offset_deadband_average (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // acc_raw_x, acc_raw_y, acc_raw_z, rate_raw_x, rate_raw_y, rate_raw_z, zero pad
    input  logic [iodba_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // acc_avg_x, acc_avg_y, acc_avg_z, rot_avg_x, rot_avg_y, rot_avg_z, zero pad
    output logic [iodba_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input  logic                                 i_cfg_we,
    input  logic [iodba_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [iodba_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int ACC_W  = iodba_pkg::ACC_W;
    localparam int RATE_W = iodba_pkg::RATE_W;
    localparam int OUT_W  = iodba_pkg::OUT_W;
    localparam int GAIN_W = iodba_pkg::GAIN_W;
    localparam int THR_W  = iodba_pkg::THR_W;

    logic [GAIN_W-1:0] r_acc_gain;
    logic [GAIN_W-1:0] r_rate_gain;
    logic [THR_W-1:0]  r_acc_thr;
    logic [THR_W-1:0]  r_rate_thr;

    logic r_s0_valid;
    logic r_a_valid;
    logic r_b_valid;
    logic r_c_valid;

    iodba_pkg::t_raw        r_raw  [iodba_pkg::AXES];
    iodba_pkg::t_raw        n_raw  [iodba_pkg::AXES];
    iodba_pkg::t_ofs        ofs    [iodba_pkg::AXES];
    iodba_pkg::t_val        cur    [iodba_pkg::AXES];
    iodba_pkg::t_wsum       wsum   [iodba_pkg::AXES];
    iodba_pkg::t_val        mean   [iodba_pkg::AXES];
    iodba_pkg::t_cal_status cal_st;

    logic s_accept;
    logic c_ready;
    logic b_ready;
    logic a_ready;
    logic b_fire;
    logic a_fire;
    logic s0_fire;
    logic cal_take;
    logic load_a;

    // Each stage moves on when the next is empty or moving; input waits if busy.
    assign c_ready  = !r_c_valid || i_m_axis_tready;
    assign b_fire   = r_b_valid && c_ready;
    assign b_ready  = !r_b_valid || c_ready;
    assign a_fire   = r_a_valid && b_ready;
    assign a_ready  = !r_a_valid || b_ready;
    assign s0_fire  = r_s0_valid && a_ready && !cal_st.busy;
    assign cal_take = s0_fire && !cal_st.done;
    assign load_a   = s0_fire && cal_st.done;

    assign o_s_axis_tready = !r_s0_valid || s0_fire;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_c_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_gain  <= iodba_pkg::GAIN_RST;
            r_rate_gain <= iodba_pkg::GAIN_RST;
            r_acc_thr   <= iodba_pkg::THR_RST;
            r_rate_thr  <= iodba_pkg::THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                iodba_pkg::REG_ACC_GAIN:  r_acc_gain  <= GAIN_W'(i_cfg_wdata);
                iodba_pkg::REG_RATE_GAIN: r_rate_gain <= GAIN_W'(i_cfg_wdata);
                iodba_pkg::REG_ACC_THR:   r_acc_thr   <= THR_W'(i_cfg_wdata);
                iodba_pkg::REG_RATE_THR:  r_rate_thr  <= THR_W'(i_cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int a = 0; a < iodba_pkg::AXES; a++) begin
            if (a < iodba_pkg::ACC_AXES) begin
                n_raw[a] = RATE_W'(signed'(i_s_axis_tdata[a*ACC_W +: ACC_W]));
            end else begin
                n_raw[a] = signed'(i_s_axis_tdata[iodba_pkg::ACC_AXES*ACC_W
                                   + (a - iodba_pkg::ACC_AXES)*RATE_W +: RATE_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_raw <= n_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
        end else begin
            if (s_accept) begin
                r_s0_valid <= 1'b1;
            end else if (s0_fire) begin
                r_s0_valid <= 1'b0;
            end
            if (load_a) begin
                r_a_valid <= 1'b1;
            end else if (a_fire) begin
                r_a_valid <= 1'b0;
            end
            if (a_fire) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (b_fire) begin
                r_c_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_c_valid <= 1'b0;
            end
        end
    end

    iodba_cal u_cal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (cal_take),
        .i_raw    (r_raw),
        .o_status (cal_st),
        .o_ofs    (ofs)
    );

    iodba_scale u_scale (
        .i_clk       (i_clk),
        .i_load      (load_a),
        .i_raw       (r_raw),
        .i_ofs       (ofs),
        .i_acc_gain  (r_acc_gain),
        .i_rate_gain (r_rate_gain),
        .i_acc_thr   (r_acc_thr),
        .i_rate_thr  (r_rate_thr),
        .o_val       (cur)
    );

    iodba_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (a_fire),
        .i_val   (cur),
        .o_sum   (wsum)
    );

    iodba_mean u_mean (
        .i_clk  (i_clk),
        .i_load (b_fire),
        .i_sum  (wsum),
        .o_mean (mean)
    );

    always_comb begin
        o_m_axis_tdata = '0;
        for (int a = 0; a < iodba_pkg::AXES; a++) begin
            o_m_axis_tdata[a*OUT_W +: OUT_W] = mean[a];
        end
    end

    // Nothing leaves the input register while the offsets are being formed.
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cal_st.busy |-> !s0_fire)
        else $error("sample advanced while offsets were being formed");

    // Only samples after calibration reach the gain stage.
    a_load_after_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_a |-> (cal_st.done && !cal_st.busy))
        else $error("sample conditioned before calibration finished");

    // The offset cycle follows a calibration sample directly.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cal_st.busy |-> $past(cal_take))
        else $error("offset update without a calibration sample");

    // A new result only appears after the window stage handed one over.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_c_valid) |-> $past(b_fire))
        else $error("output valid without a window result");

endmodule

// File: bench/imu_offset_deadband_average_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the IMU block's window means and compares every output transaction.
module imu_offset_deadband_average_checker
    import iodba_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    output int                     o_mismatches,
    output int                     o_outstanding
);

    localparam int     MEAN_W   = AXES * OUT_W;
    localparam longint LANE_MAX = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint LANE_MIN = -(longint'(1) << (OUT_W - 1));

    logic [GAIN_W-1:0] acc_gain_q;
    logic [GAIN_W-1:0] rate_gain_q;
    logic [THR_W-1:0]  acc_thr_q;
    logic [THR_W-1:0]  rate_thr_q;

    int     cal_seen;
    longint cal_acc [AXES];
    longint axis_ofs [AXES];
    longint window_hist [WINDOW][AXES];

    logic [MEAN_W-1:0] mean_queue [$];
    int mismatch_count = 0;

    function automatic longint clip_lane(input longint v);
        if (v > LANE_MAX) return LANE_MAX;
        if (v < LANE_MIN) return LANE_MIN;
        return v;
    endfunction

    // Q16 gain applied to a count difference leaves a Q8 value; small values fall in the deadband.
    function automatic longint scale_and_deadband(input longint diff, input longint gain,
                                                  input longint thr);
        longint v;
        v = clip_lane((diff * gain) / 256);
        if ((v < 0 ? -v : v) < thr) v = 0;
        return v;
    endfunction

    task automatic absorb_sample(input logic [IN_TDATA_W-1:0] word);
        longint raw [AXES];
        longint sum;
        int src;
        logic [MEAN_W-1:0] mean_word;
        for (int a = 0; a < AXES; a++) begin
            if (a < ACC_AXES)
                raw[a] = longint'($signed(word[a*ACC_W +: ACC_W]));
            else
                raw[a] = longint'($signed(word[ACC_AXES*ACC_W + (a-ACC_AXES)*RATE_W +: RATE_W]));
        end
        if (cal_seen < CAL_SAMPLES) begin
            for (int a = 0; a < AXES; a++) cal_acc[a] += raw[a];
            cal_seen++;
            if (cal_seen == CAL_SAMPLES) begin
                for (int a = 0; a < AXES; a++) axis_ofs[a] = cal_acc[a] / CAL_SAMPLES;
                axis_ofs[AXIS_ACC_Z] -= ONE_G;
            end
        end else begin
            for (int k = WINDOW - 1; k > 0; k--)
                for (int a = 0; a < AXES; a++) window_hist[k][a] = window_hist[k-1][a];
            for (int a = 0; a < AXES; a++) begin
                // The rotation lanes for x and y take the opposite gyro axis.
                src = (a == AXIS_RATE_X) ? AXIS_RATE_Y : (a == AXIS_RATE_Y) ? AXIS_RATE_X : a;
                if (a < ACC_AXES)
                    window_hist[0][a] = scale_and_deadband(raw[src] - axis_ofs[src],
                                                           longint'(acc_gain_q),
                                                           longint'(acc_thr_q));
                else
                    window_hist[0][a] = scale_and_deadband(raw[src] - axis_ofs[src],
                                                           longint'(rate_gain_q),
                                                           longint'(rate_thr_q));
                sum = 0;
                for (int k = 0; k < WINDOW; k++) sum += window_hist[k][a];
                mean_word[a*OUT_W +: OUT_W] = OUT_W'(clip_lane(sum / WINDOW));
            end
            mean_queue.push_back(mean_word);
        end
    endtask

    task automatic compare_mean(input logic [OUT_TDATA_W-1:0] word);
        logic [MEAN_W-1:0] want;
        if (mean_queue.size() == 0) begin
            $display("%0t: mean transaction with none pending: expected nothing, actual %h",
                     $time, word[MEAN_W-1:0]);
            mismatch_count++;
        end else begin
            want = mean_queue.pop_front();
            for (int a = 0; a < AXES; a++) begin
                if (word[a*OUT_W +: OUT_W] !== want[a*OUT_W +: OUT_W]) begin
                    $display("%0t: lane %0d expected %0d actual %0d", $time, a,
                             $signed(want[a*OUT_W +: OUT_W]), $signed(word[a*OUT_W +: OUT_W]));
                    mismatch_count++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc_gain_q  = GAIN_RST;
            rate_gain_q = GAIN_RST;
            acc_thr_q   = THR_RST;
            rate_thr_q  = THR_RST;
            cal_seen    = 0;
            for (int a = 0; a < AXES; a++) begin
                cal_acc[a]  = 0;
                axis_ofs[a] = 0;
                for (int k = 0; k < WINDOW; k++) window_hist[k][a] = 0;
            end
            mean_queue.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) compare_mean(i_m_tdata);
            if (i_s_tvalid && i_s_tready) absorb_sample(i_s_tdata);
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_ACC_GAIN:  acc_gain_q  = i_cfg_wdata[GAIN_W-1:0];
                    REG_RATE_GAIN: rate_gain_q = i_cfg_wdata[GAIN_W-1:0];
                    REG_ACC_THR:   acc_thr_q   = i_cfg_wdata[THR_W-1:0];
                    REG_RATE_THR:  rate_thr_q  = i_cfg_wdata[THR_W-1:0];
                    default: ;
                endcase
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= mean_queue.size();
    end

endmodule

// File: bench/tb_imu_offset_deadband_average.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, sample and register stimulus, and the final verdict.
module tb_imu_offset_deadband_average;
    import iodba_pkg::*;

    localparam int CYCLE_LIMIT      = 500000;
    localparam int DRAIN_PAUSE      = 8;
    localparam int LONG_HOLD_AT     = 260;
    localparam int LONG_HOLD_CYCLES = 400;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int     mismatches;
    int     outstanding;
    int     sample_f [AXES];
    int     aim [AXES];
    longint cal_total [AXES];
    int     items_sent = 0;
    bit     calm = 0;
    bit     long_hold_done = 0;
    int     cycle_count = 0;

    imu_offset_deadband_average u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    imu_offset_deadband_average_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random stalls, one long hold-off so the pipeline backs up into the input.
    initial begin
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!long_hold_done && items_sent >= LONG_HOLD_AT) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    function automatic int pick_field(input int axis);
        int lo;
        int hi;
        int spread;
        int v;
        lo     = (axis < ACC_AXES) ? -(1 << (ACC_W - 1)) : -(1 << (RATE_W - 1));
        hi     = -lo - 1;
        spread = (axis < ACC_AXES) ? 6 : 80;
        case ($urandom_range(0, 9))
            0: v = lo;
            1: v = hi;
            // Near the calibrated offset, where the deadband edges lie.
            2, 3, 4: v = aim[axis] + int'($urandom_range(0, 2 * spread)) - spread;
            default: v = lo + int'($urandom_range(0, hi - lo));
        endcase
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    // Leaves tvalid high after the transaction; the caller lowers it when the stream pauses.
    task automatic send_sample();
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        for (int a = 0; a < AXES; a++) begin
            if (a < ACC_AXES)
                word[a*ACC_W +: ACC_W] = sample_f[a][ACC_W-1:0];
            else
                word[ACC_AXES*ACC_W + (a-ACC_AXES)*RATE_W +: RATE_W] = sample_f[a][RATE_W-1:0];
        end
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_six(input int ax, input int ay, input int az,
                            input int gx, input int gy, input int gz);
        sample_f[0] = ax;
        sample_f[1] = ay;
        sample_f[2] = az;
        sample_f[3] = gx;
        sample_f[4] = gy;
        sample_f[5] = gz;
        send_sample();
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic drain();
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic reconfigure_and_stream(input logic [CFG_DATA_W-1:0] acc_gain,
                                          input logic [CFG_DATA_W-1:0] rate_gain,
                                          input logic [CFG_DATA_W-1:0] acc_thr,
                                          input logic [CFG_DATA_W-1:0] rate_thr,
                                          input int count);
        drain();
        write_reg(REG_ACC_GAIN, acc_gain);
        write_reg(REG_RATE_GAIN, rate_gain);
        write_reg(REG_ACC_THR, acc_thr);
        write_reg(REG_RATE_THR, rate_thr);
        cfg_we <= 1'b0;
        repeat (count) begin
            for (int a = 0; a < AXES; a++) sample_f[a] = pick_field(a);
            send_sample();
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        int acc_lo;
        int acc_hi;
        int rate_lo;
        int rate_hi;
        int d_ax;
        int d_ay;
        int d_gx;
        int d_gy;
        acc_lo  = -(1 << (ACC_W - 1));
        acc_hi  = (1 << (ACC_W - 1)) - 1;
        rate_lo = -(1 << (RATE_W - 1));
        rate_hi = (1 << (RATE_W - 1)) - 1;
        for (int a = 0; a < AXES; a++) cal_total[a] = 0;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_addr      <= '0;
        cfg_wdata     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Calibration in mirrored pairs, so the x and y offsets land well inside the range and
        // later samples give differences of both signs; the first pair hits the extremes.
        for (int k = 0; k < CAL_SAMPLES / 2; k++) begin
            d_ax = (k == 0) ? 256 : int'($urandom_range(0, 256));
            d_ay = (k == 0) ? 256 : int'($urandom_range(0, 256));
            d_gx = (k == 0) ? 16384 : int'($urandom_range(0, 16384));
            d_gy = (k == 0) ? 16384 : int'($urandom_range(0, 16384));
            for (int s = 0; s < 2; s++) begin
                send_six(s == 0 ? -256 - d_ax : -256 + d_ax,
                         s == 0 ? 255 + d_ay : 255 - d_ay,
                         acc_lo + int'($urandom_range(0, acc_hi - acc_lo)),
                         s == 0 ? -16384 - d_gx : -16384 + d_gx,
                         s == 0 ? 16383 + d_gy : 16383 - d_gy,
                         rate_lo + int'($urandom_range(0, rate_hi - rate_lo)));
                for (int a = 0; a < AXES; a++) cal_total[a] += sample_f[a];
            end
        end
        for (int a = 0; a < AXES; a++) aim[a] = int'(cal_total[a] / CAL_SAMPLES);
        aim[AXIS_ACC_Z] -= ONE_G;
        if (aim[AXIS_ACC_Z] < acc_lo) aim[AXIS_ACC_Z] = acc_lo;

        // Directed samples under the reset gains and thresholds.
        send_six(0, 0, 0, 0, 0, 0);
        send_six(acc_lo, acc_lo, acc_lo, rate_lo, rate_lo, rate_lo);
        send_six(acc_hi, acc_hi, acc_hi, rate_hi, rate_hi, rate_hi);
        send_six(aim[0], aim[1], aim[2], aim[3], aim[4], aim[5]);
        send_six(aim[0] + 1, aim[1] + 1, aim[2] + 1, aim[3] + 1, aim[4] + 1, aim[5] + 1);
        send_six(aim[0] - 1, aim[1] - 1, aim[2] - 1, aim[3] - 1, aim[4] - 1, aim[5] - 1);
        send_six(-1, -1, -1, -1, -1, -1);
        send_six(acc_lo, acc_hi, acc_lo, rate_hi, rate_lo, rate_hi);
        send_six(acc_hi, acc_lo, acc_hi, rate_lo, rate_hi, rate_lo);
        // A run of WINDOW - 1 samples of the largest positive differences.
        repeat (WINDOW - 1) send_six(acc_hi, acc_hi, acc_hi, rate_hi, rate_hi, rate_hi);
        s_axis_tvalid <= 1'b0;

        // Largest gains, given with bits above the register width set.
        reconfigure_and_stream('1, '1, '0, '0, 150);
        reconfigure_and_stream('0, '0, '0, '0, 60);
        reconfigure_and_stream(CFG_DATA_W'(1), CFG_DATA_W'(1), '0, '0, 80);
        reconfigure_and_stream(CFG_DATA_W'(GAIN_RST), CFG_DATA_W'(GAIN_RST), '1, '0, 40);
        reconfigure_and_stream(CFG_DATA_W'(GAIN_RST), CFG_DATA_W'(GAIN_RST), '0, '1, 40);
        // Thresholds on exact multiples of one scaled count, to land on the deadband edge.
        reconfigure_and_stream(CFG_DATA_W'(GAIN_RST), CFG_DATA_W'(GAIN_RST),
                               CFG_DATA_W'(4 * 256), CFG_DATA_W'(40 * 256), 200);
        repeat (4) begin
            reconfigure_and_stream(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                   CFG_DATA_W'($urandom_range(0, 1 << 22)),
                                   CFG_DATA_W'($urandom_range(0, 1 << 22)), 100);
        end
        calm = 1;
        reconfigure_and_stream(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                               CFG_DATA_W'($urandom_range(0, 1 << 16)),
                               CFG_DATA_W'($urandom_range(0, 1 << 20)), 250);

        drain();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
